// ===== hdl/b64e_pkg.sv =====
// shared types, constants and the symbol-to-character map of the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

  localparam int unsigned SymbolsPerGroup = 4;

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;  // 'a'
  localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;  // '0'
  localparam logic [6:0] CHAR_SYM_62 = 7'h2E;  // '.'
  localparam logic [6:0] CHAR_SYM_63 = 7'h3A;  // ':'

  localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SYM_62 = 6'd62;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_end;
    logic       message_end;
  } char_t;

  // one finished group of four characters
  typedef struct packed {
    logic [SymbolsPerGroup-1:0][6:0] chars;
    logic                            fin;
  } group_t;

  // serializer status back to the group assembly
  typedef struct packed {
    logic free;  // a group can be loaded at this edge
  } ser_status_t;

  function automatic logic [6:0] sym_char(input logic [5:0] sym);
    logic [6:0] c;
    if (sym < SYM_LOWER_BASE) begin
      c = 7'(CHAR_UPPER_A + {1'b0, sym});
    end else if (sym < SYM_DIGIT_BASE) begin
      c = 7'(CHAR_LOWER_A + {1'b0, sym - SYM_LOWER_BASE});
    end else if (sym < SYM_62) begin
      c = 7'(CHAR_DIGIT_0 + {1'b0, sym - SYM_DIGIT_BASE});
    end else if (sym == SYM_62) begin
      c = CHAR_SYM_62;
    end else begin
      c = CHAR_SYM_63;
    end
    return c;
  endfunction

endpackage

// ===== hdl/b64e_serializer.sv =====
// result register holding one four-character group, sent out one character per transaction
`timescale 1ns / 1ps

module b64e_serializer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  b64e_pkg::group_t      group_in,
  output b64e_pkg::ser_status_t status,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64e_pkg::char_t       char_data
);

  b64e_pkg::group_t group_q;
  logic             busy;
  logic [1:0]       idx;
  logic             taken;
  logic             last_taken;

  assign taken      = busy && !char_stall;
  assign last_taken = taken && (idx == 2'(b64e_pkg::SymbolsPerGroup - 1));

  assign status.free = !busy || last_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (taken) begin
      if (last_taken) begin
        busy <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      group_q <= group_in;
    end
  end

  assign char_valid            = busy;
  assign char_data.out_char    = group_q.chars[idx];
  assign char_data.run_end     = (idx == 2'(b64e_pkg::SymbolsPerGroup - 1));
  assign char_data.message_end = (idx == 2'(b64e_pkg::SymbolsPerGroup - 1)) && group_q.fin;

endmodule

// ===== hdl/base64_stream_encoder.sv =====
// top level of the streaming base64 encoder: group assembly, symbol mapping, assertions
`timescale 1ns / 1ps

// base64_stream_encoder
// byte channel: one raw byte per transaction, final_byte marks the last byte of a message
// char channel: one 7-bit ascii character per transaction, with run_end on the fourth
//   character of each group and message_end on the fourth character of the message's last group
// up to two bytes wait in the group buffer; a non-final byte that does not close a group
//   is taken without a stall and causes no characters
// a byte that closes a group (third byte, or a final byte) is mapped in the same cycle and
//   loaded into the character register; its first character shows in the next cycle
// the character register sends one character per cycle while char_stall is low, so a
//   group of three bytes leaves as four characters, paced by the one-character port
// a closing byte is taken while the previous group's last character leaves, so groups
//   follow with no gap; byte_stall rises only when a closing byte meets a busy register
// a final byte closing a partial group zero-fills it and pads with '=' to four characters
// reset clears the byte count and empties the character register; no clearing pass
// while char_stall is high the current character holds and the block keeps taking
//   non-closing bytes until a closing byte needs the register

module base64_stream_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  b64e_pkg::byte_t   byte_data,
  output logic              char_valid,
  input  logic              char_stall,
  output b64e_pkg::char_t   char_data
);

  // group buffer: bytes of the open group and how many are held
  logic [1:0][7:0] pending;
  logic [1:0]      count;
  logic [1:0]      count_next;

  logic [1:0]       held;
  logic             closes;
  logic             accept;
  logic             load;
  logic [7:0]       g0, g1, g2;
  logic [5:0]       sym0, sym1, sym2, sym3;
  b64e_pkg::group_t group_next;
  b64e_pkg::ser_status_t ser_status;

  // a count of three cannot arise; it is read as empty
  assign held   = (count == 2'd3) ? 2'd0 : count;
  assign closes = (held == 2'd2) || byte_data.final_byte;

  assign byte_stall = closes && !ser_status.free;
  assign accept     = byte_valid && !byte_stall;
  assign load       = accept && closes;

  // assemble the group, missing bytes read as zero
  always_comb begin
    g0 = byte_data.data_byte;
    g1 = '0;
    g2 = '0;
    case (held)
      2'd1: begin
        g0 = pending[0];
        g1 = byte_data.data_byte;
      end
      2'd2: begin
        g0 = pending[0];
        g1 = pending[1];
        g2 = byte_data.data_byte;
      end
      default: begin
        g0 = byte_data.data_byte;
      end
    endcase
  end

  // split 24 bits into four 6-bit symbols
  assign sym0 = g0[7:2];
  assign sym1 = {g0[1:0], g1[7:4]};
  assign sym2 = {g1[3:0], g2[7:6]};
  assign sym3 = g2[5:0];

  // first two characters are always symbols; later ones pad when the group is short
  always_comb begin
    group_next.chars[0] = b64e_pkg::sym_char(sym0);
    group_next.chars[1] = b64e_pkg::sym_char(sym1);
    group_next.chars[2] = (held != 2'd0) ? b64e_pkg::sym_char(sym2) : b64e_pkg::PAD_CHAR;
    group_next.chars[3] = (held == 2'd2) ? b64e_pkg::sym_char(sym3) : b64e_pkg::PAD_CHAR;
    group_next.fin      = byte_data.final_byte;
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = closes ? 2'd0 : held + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // only written for non-closing bytes, held is then 0 or 1
  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      pending[held[0]] <= byte_data.data_byte;
    end
  end

  b64e_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .group_in   (group_next),
    .status     (ser_status),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the byte count never reaches three
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("byte count reached three");

  // a closing byte always produces a character in the next cycle
  a_group_out: assert property (@(posedge clk) disable iff (rst)
    load |=> char_valid && !char_data.run_end)
    else $error("closing byte did not start a group");

  // a non-closing byte advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !closes |=> count == $past(held) + 2'd1)
    else $error("byte count did not advance");

  // end of message only on the last character of a group
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.message_end |-> char_data.run_end)
    else $error("message end off a group boundary");

endmodule

// ===== dv/tb_base64_stream_encoder.sv =====
// self-checking testbench of the base64 stream encoder with its own character predictor
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 16;
  localparam logic [6:0] PadAscii = 7'h3D;  // '='

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            byte_valid = 1'b0;
  logic            byte_stall;
  b64e_pkg::byte_t byte_data = '0;
  logic            char_valid;
  logic            char_stall = 1'b0;
  b64e_pkg::char_t char_data;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold, counted down by the receiver process
  int unsigned hold_left = 0;

  // predictor state: bytes of the open group and how many are held
  logic [7:0] open_bytes[2];
  logic [1:0] open_count = 2'd0;

  // characters still owed by the block, oldest first
  b64e_pkg::char_t encoded_chars_q[$];

  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned chars_checked = 0;

  base64_stream_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // 6-bit symbol to its character: A-Z, a-z, 0-9, '.', ':'
  function automatic logic [6:0] ascii_of_symbol(input logic [5:0] s);
    int v;
    logic [6:0] c;
    v = int'(s);
    if (v < 26) c = 7'(v + 65);  // 'A' + s
    else if (v < 52) c = 7'(v + 71);  // 'a' + s - 26
    else if (v < 62) c = 7'(v - 4);  // '0' + s - 52
    else if (v == 62) c = 7'h2E;  // '.'
    else c = 7'h3A;  // ':'
    return c;
  endfunction

  // predict the characters caused by one accepted byte transaction
  task automatic encode_byte(input logic [7:0] d, input logic fin);
    logic [7:0] grp[3];
    logic [23:0] bits;
    int unsigned held;
    int unsigned total;
    int unsigned nsym;
    b64e_pkg::char_t c;
    held = open_count;
    grp[0] = 8'h00;
    grp[1] = 8'h00;
    grp[2] = 8'h00;
    for (int k = 0; k < held; k++) grp[k] = open_bytes[k];
    grp[held] = d;
    total = held + 1;
    // partial group that is not the end of the message: just hold the byte
    if (total < 3 && !fin) begin
      open_bytes[held] = d;
      open_count = 2'(total);
      return;
    end
    bits = {grp[0], grp[1], grp[2]};
    // zero-filled partial group keeps count+1 symbols, the rest is padding
    nsym = (total == 3) ? 4 : total + 1;
    for (int k = 0; k < 4; k++) begin
      c.out_char = (k < nsym) ? ascii_of_symbol(bits[23 - 6 * k -: 6]) : PadAscii;
      c.run_end = (k == 3);
      c.message_end = (k == 3) && fin;
      encoded_chars_q.push_back(c);
    end
    open_count = 2'd0;
  endtask

  // receiver side: stall pattern changes at the falling edge
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        char_stall = 1'b1;
        hold_left--;
      end else begin
        char_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker, compares each char transaction with the oldest prediction
  always @(posedge clk) begin : check_chars
    b64e_pkg::char_t want;
    if (!rst && char_valid && !char_stall) begin
      if (encoded_chars_q.size() == 0) begin
        $error("unexpected character 0x%02h with nothing predicted", char_data.out_char);
        err_count++;
      end else begin
        want = encoded_chars_q.pop_front();
        chars_checked++;
        if (char_data.out_char !== want.out_char) begin
          $error("out_char: expected 0x%02h, got 0x%02h", want.out_char, char_data.out_char);
          err_count++;
        end
        if (char_data.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, char_data.run_end);
          err_count++;
        end
        if (char_data.message_end !== want.message_end) begin
          $error("message_end: expected %0b, got %0b", want.message_end,
                 char_data.message_end);
          err_count++;
        end
      end
    end
  end

  // offer one byte transaction; entered and left at a falling edge, valid stays high
  // on return so that back-to-back transactions leave no gap
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid = 1'b0;
      @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_data = {d, fin};
    do @(posedge clk); while (byte_stall);
    encode_byte(d, fin);
    bytes_sent++;
    if (fin) messages_sent++;
    @(negedge clk);
  endtask

  // drop valid and hold off until every predicted character has been seen
  task automatic wait_drained();
    byte_valid = 1'b0;
    while (encoded_chars_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // extremes, every group shape, both special characters, padding of one and two
  task automatic test_directed();
    send_byte(8'h00, 1'b1);  // one byte, two pads
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);  // two bytes, one pad
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);  // full group ending the message, all ':'
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF8, 1'b0);  // '.' first, then a full group not ending the message
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);  // single trailing byte after a full group
    send_byte(8'h55, 1'b0);  // alternating bits
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);  // two trailing bytes after a full group
    send_byte(8'h00, 1'b0);  // all zero group
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFE, 1'b0);  // digits range
    send_byte(8'hEF, 1'b1);
    wait_drained();
  endtask

  // mostly well-formed messages with random content, some loose bytes with a random flag
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 85) begin
        send_message($urandom_range(1, ($urandom_range(9) == 0) ? 24 : 8));
      end else begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the block fills
  task automatic test_char_backpressure();
    hold_left = 120;
    for (int i = 0; i < 3; i++) send_message(9);
    send_message(4);
    wait_drained();
  endtask

  // sender pauses mid-message until every character is out, with bytes still held
  task automatic test_sender_pause();
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    repeat (TailCycles) @(negedge clk);
    send_byte(8'($urandom_range(255)), 1'b1);
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    repeat (TailCycles) @(negedge clk);
    send_byte(8'($urandom_range(255)), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();

    // slow receiver, busy sender
    send_idle_pct = 14;
    recv_stall_pct = 86;
    test_random_traffic(100);
    test_sender_pause();

    // busy receiver, slow sender
    send_idle_pct = 86;
    recv_stall_pct = 14;
    test_random_traffic(100);

    // no idling on either side
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(100);
    test_char_backpressure();

    byte_valid = 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (encoded_chars_q.size() != 0) begin
      $error("%0d predicted characters never arrived", encoded_chars_q.size());
      err_count++;
    end

    $display("run covered %0d byte transactions in %0d messages, %0d characters checked",
             bytes_sent, messages_sent, chars_checked);
    $display("idle mixes 14/86, 86/14 and none, plus a long char hold and a sender pause");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/b64e_pkg.sv
hdl/b64e_serializer.sv
hdl/base64_stream_encoder.sv
dv/tb_base64_stream_encoder.sv
